### rtl/lmss_pkg.sv
`default_nettype none
package lmss_pkg;

  // Frame store geometry. Field widths of the item fix these.
  localparam int MAX_FRAME_WIDTH = 256;
  localparam int MAX_ROWS        = 16;
  localparam int COL_W           = 8;
  localparam int ROW_W           = 4;
  localparam int ADDR_W          = ROW_W + COL_W;
  localparam int PIX_W           = 2;

  // Configuration port.
  localparam int CFG_W    = 9;
  localparam int WIDTH_W  = 9;
  localparam int RCNT_W   = 5;
  localparam int TALLY_W  = 8;

  // Classified item queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Remainder unit operand width: scroll offset plus column index.
  localparam int MOD_W   = 9;
  localparam int MODCNT_W = $clog2(MOD_W + 1);

  typedef enum logic [1:0] {
    CFG_VISIBLE_WIDTH,
    CFG_ROW_COUNT,
    CFG_FRAME_WIDTH,
    CFG_SCROLL_DIVIDER
  } cfg_idx_t;

  // Effective (clamped) configuration, with a few derived values.
  typedef struct packed {
    logic [COL_W-1:0]   vw_m1;
    logic [RCNT_W-1:0]  rc_eff;
    logic [ROW_W-1:0]   rc_m1;
    logic [WIDTH_W-1:0] fw_eff;
    logic [TALLY_W-1:0] div_eff;
  } cfg_t;

  // One classified item as held in the queue.
  typedef struct packed {
    logic              is_tick;
    logic              oor;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  color;
  } q_entry_t;

endpackage
`default_nettype wire

### rtl/lmss_if.sv
`default_nettype none
interface lmss_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] pixel_x;
  logic [3:0] pixel_y;
  logic [1:0] pixel_color;

  modport source (output valid, output action, output pixel_x, output pixel_y,
                  output pixel_color, input ready);
  modport sink (input valid, input action, input pixel_x, input pixel_y,
                input pixel_color, output ready);
endinterface

interface lmss_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [3:0] row_address;
  logic       red_low;
  logic       green_low;
  logic       latch;
  logic       frame_done;

  modport source (output valid, output status, output row_address, output red_low,
                  output green_low, output latch, output frame_done, input ready);
  modport sink (input valid, input status, input row_address, input red_low,
                input green_low, input latch, input frame_done, output ready);
endinterface
`default_nettype wire

### rtl/led_matrix_scan_scroll_core.sv
`default_nettype none
// Channel   Dir  Handshake          Payload
// in_ch     in   valid / ready      action, pixel_x, pixel_y, pixel_color
// out_ch    out  valid / ready      status, row_address, red_low, green_low, latch, frame_done
// cfg_*     in   cfg_we (no wait)   cfg_index, cfg_wdata
//
// One transfer per cycle on each channel unless stalled (busy, full queue, out_ch.ready low);
// an input transfer passes the queue entry, decode stage and output register to out_ch.
// After reset a clearing pass writes all 4096 pixels, one per cycle, and the scroll and column
// pointers are then reduced modulo the frame width; in_ch.ready stays low until both are done.
// A frame_width write holds in_ch.ready low while that reduction runs again;
// output stalls back up through the result pipeline into the four-entry queue before it drops.
module led_matrix_scan_scroll_core (
  input  logic                            clk,
  input  logic                            rst_n,
  lmss_in_if.sink                         in_ch,
  lmss_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  lmss_pkg::cfg_idx_t              cfg_index,
  input  logic [lmss_pkg::CFG_W-1:0]      cfg_wdata
);
  import lmss_pkg::*;

  // Configuration is kept in its clamped form, so the datapath never has to
  // handle a zero or oversized width, row count or divider.
  logic [COL_W-1:0]   vw_m1_r;
  logic [RCNT_W-1:0]  rc_eff_r;
  logic [ROW_W-1:0]   rc_m1_r;
  logic [WIDTH_W-1:0] fw_eff_r;
  logic [TALLY_W-1:0] div_eff_r;
  logic               fw_wr_r;

  logic [WIDTH_W-1:0] width_cl;
  logic [RCNT_W-1:0]  rows_cl;
  logic [TALLY_W-1:0] div_cl;

  cfg_t               cfg;
  logic               busy;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  q_entry_t           q_in;
  q_entry_t           q_out;

  always_comb begin
    if (cfg_wdata == '0) begin
      width_cl = WIDTH_W'(1);
    end else if (cfg_wdata > WIDTH_W'(MAX_FRAME_WIDTH)) begin
      width_cl = WIDTH_W'(MAX_FRAME_WIDTH);
    end else begin
      width_cl = cfg_wdata;
    end
    if (cfg_wdata[RCNT_W-1:0] == '0) begin
      rows_cl = RCNT_W'(1);
    end else if (cfg_wdata[RCNT_W-1:0] > RCNT_W'(MAX_ROWS)) begin
      rows_cl = RCNT_W'(MAX_ROWS);
    end else begin
      rows_cl = cfg_wdata[RCNT_W-1:0];
    end
    if (cfg_wdata[TALLY_W-1:0] == '0) begin
      div_cl = TALLY_W'(1);
    end else begin
      div_cl = cfg_wdata[TALLY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_m1_r   <= COL_W'(63);
      rc_eff_r  <= RCNT_W'(8);
      rc_m1_r   <= ROW_W'(7);
      fw_eff_r  <= WIDTH_W'(64);
      div_eff_r <= TALLY_W'(5);
      fw_wr_r   <= 1'b0;
    end else begin
      fw_wr_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_VISIBLE_WIDTH: begin
            vw_m1_r <= COL_W'(width_cl - 1'b1);
          end
          CFG_ROW_COUNT: begin
            rc_eff_r <= rows_cl;
            rc_m1_r  <= ROW_W'(rows_cl - 1'b1);
          end
          CFG_FRAME_WIDTH: begin
            fw_eff_r <= width_cl;
            // The back end re-reduces its pointers once the new width is in place.
            fw_wr_r  <= 1'b1;
          end
          CFG_SCROLL_DIVIDER: begin
            div_eff_r <= div_cl;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    cfg.vw_m1   = vw_m1_r;
    cfg.rc_eff  = rc_eff_r;
    cfg.rc_m1   = rc_m1_r;
    cfg.fw_eff  = fw_eff_r;
    cfg.div_eff = div_eff_r;
  end

  // Front end: bounds check and classification of each transfer.
  lmss_front u_front (
    .in_ch  (in_ch),
    .cfg    (cfg),
    .busy   (busy),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // Short queue so that input and output stall independently.
  lmss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .valid     (q_valid)
  );

  // Back end: scan state, frame store and result pipeline.
  lmss_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .fw_wr   (fw_wr_r),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .busy    (busy),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

### rtl/lmss_queue.sv
`default_nettype none
module lmss_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lmss_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output lmss_pkg::q_entry_t pop_data,
  output logic              valid
);
  import lmss_pkg::*;

  q_entry_t            entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W:0]     count_r;

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= (QPTR_W+1)'(QUEUE_DEPTH)) && !(pop && !valid))
    else $error("queue count out of range or pop from empty queue");
`endif

endmodule
`default_nettype wire

### rtl/lmss_front.sv
`default_nettype none
module lmss_front (
  lmss_in_if.sink            in_ch,
  input  lmss_pkg::cfg_t     cfg,
  input  logic               busy,
  input  logic               q_full,
  output logic               q_push,
  output lmss_pkg::q_entry_t q_data
);
  import lmss_pkg::*;

  logic x_oor;
  logic y_oor;

  // Bounds check against the effective frame size.
  assign x_oor = ({1'b0, in_ch.pixel_x} >= cfg.fw_eff);
  assign y_oor = ({1'b0, in_ch.pixel_y} >= cfg.rc_eff);

  assign in_ch.ready = !q_full && !busy;
  assign q_push      = in_ch.valid && in_ch.ready;

  always_comb begin
    q_data.is_tick = in_ch.action;
    q_data.oor     = !in_ch.action && (x_oor || y_oor);
    q_data.wr_en   = !in_ch.action && !(x_oor || y_oor);
    q_data.addr    = {in_ch.pixel_y, in_ch.pixel_x};
    q_data.color   = in_ch.pixel_color;
  end

endmodule
`default_nettype wire

### rtl/lmss_mod.sv
`default_nettype none
module lmss_mod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lmss_pkg::MOD_W-1:0]    dividend,
  input  logic [lmss_pkg::WIDTH_W-1:0]  divisor,
  output logic                          done,
  output logic [lmss_pkg::COL_W-1:0]    rem
);
  import lmss_pkg::*;

  logic                 run_r;
  logic [MODCNT_W-1:0]  cnt_r;
  logic [MOD_W-1:0]     src_r;
  logic [WIDTH_W-1:0]   div_r;
  logic [WIDTH_W-1:0]   rem_r;
  logic [WIDTH_W:0]     rem_sh;
  logic [WIDTH_W-1:0]   rem_nxt;

  // One restoring step per cycle, most significant dividend bit first.
  always_comb begin
    rem_sh = {rem_r, src_r[MOD_W-1]};
    if (rem_sh >= {1'b0, div_r}) begin
      rem_nxt = WIDTH_W'(rem_sh - {1'b0, div_r});
    end else begin
      rem_nxt = rem_sh[WIDTH_W-1:0];
    end
  end

  assign done = run_r && (cnt_r == '0);
  assign rem  = rem_r[COL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= MODCNT_W'(MOD_W);
    end else if (done) begin
      run_r <= 1'b0;
    end else if (run_r) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      src_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (run_r && (cnt_r != '0)) begin
      src_r <= {src_r[MOD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (rem_r < div_r))
    else $error("remainder not below divisor at completion");
`endif

endmodule
`default_nettype wire

### rtl/lmss_back.sv
`default_nettype none
module lmss_back (
  input  logic               clk,
  input  logic               rst_n,
  input  lmss_pkg::cfg_t     cfg,
  input  logic               fw_wr,
  input  logic               q_valid,
  input  lmss_pkg::q_entry_t q_data,
  output logic               q_pop,
  output logic               busy,
  lmss_out_if.source         out_ch
);
  import lmss_pkg::*;

  typedef enum logic [1:0] {
    M_CLEAR,
    M_MOD_S,
    M_MOD_C,
    M_RUN
  } mstate_t;

  mstate_t           st_r, st_nxt;
  logic [ADDR_W-1:0] clr_cnt_r;

  // Scan state.
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]   col_idx_r, col_idx_nxt;
  logic [COL_W-1:0]   scroll_raw_r, scroll_raw_nxt;
  logic [COL_W-1:0]   scroll_red_r, scroll_red_nxt;
  logic [COL_W-1:0]   col_ptr_r, col_ptr_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;

  logic [ROW_W-1:0]   row_rd;
  logic               is_latch;
  logic               is_done;
  logic [TALLY_W-1:0] tally_inc;
  logic               scroll_step;
  logic [WIDTH_W-1:0] scroll_inc;
  logic [COL_W-1:0]   scroll_wrap;
  logic [WIDTH_W-1:0] colp_inc;
  logic [COL_W-1:0]   colp_wrap;

  // Remainder unit control.
  logic               mod_start;
  logic [MOD_W-1:0]   mod_dividend;
  logic               mod_done;
  logic [COL_W-1:0]   mod_rem;

  // Frame store.
  logic [PIX_W-1:0]   mem [MAX_ROWS*MAX_FRAME_WIDTH];
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we;
  logic               mem_re;
  logic [PIX_W-1:0]   mem_wdata;
  logic [PIX_W-1:0]   rd_r;

  // Pipeline.
  logic               out_free, p1_free, p1_adv;
  logic               p1_v_r, p1_tick_r, p1_status_r, p1_latch_r, p1_done_r;
  logic [ROW_W-1:0]   p1_row_r;
  logic               out_v_r, out_status_r, out_red_r, out_green_r;
  logic               out_latch_r, out_done_r;
  logic [ROW_W-1:0]   out_row_r;

  assign busy     = (st_r != M_RUN) || fw_wr;
  assign out_free = !out_v_r || out_ch.ready;
  assign p1_free  = !p1_v_r || out_free;
  assign p1_adv   = p1_v_r && out_free;
  assign q_pop    = q_valid && p1_free && (st_r == M_RUN);

  lmss_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (cfg.fw_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Tick decode on the current scan state.
  always_comb begin
    row_rd      = ({1'b0, cur_row_r} < cfg.rc_eff) ? cur_row_r : cfg.rc_m1;
    is_latch    = (col_idx_r >= cfg.vw_m1);
    is_done     = is_latch && (cur_row_r >= cfg.rc_m1);
    tally_inc   = tally_r + 1'b1;
    scroll_step = (tally_inc >= cfg.div_eff);
    scroll_inc  = {1'b0, scroll_red_r} + 1'b1;
    scroll_wrap = (scroll_inc == cfg.fw_eff) ? '0 : scroll_inc[COL_W-1:0];
    colp_inc    = {1'b0, col_ptr_r} + 1'b1;
    colp_wrap   = (colp_inc == cfg.fw_eff) ? '0 : colp_inc[COL_W-1:0];
  end

  // Scan state update. col_ptr_r tracks the stored column that the next tick reads.
  always_comb begin
    cur_row_nxt    = cur_row_r;
    col_idx_nxt    = col_idx_r;
    scroll_raw_nxt = scroll_raw_r;
    scroll_red_nxt = scroll_red_r;
    col_ptr_nxt    = col_ptr_r;
    tally_nxt      = tally_r;
    if (q_pop && q_data.is_tick) begin
      if (!is_latch) begin
        col_idx_nxt = col_idx_r + 1'b1;
        col_ptr_nxt = colp_wrap;
      end else begin
        col_idx_nxt = '0;
        if (!is_done) begin
          cur_row_nxt = cur_row_r + 1'b1;
          col_ptr_nxt = scroll_red_r;
        end else begin
          cur_row_nxt = '0;
          if (scroll_step) begin
            tally_nxt      = '0;
            scroll_raw_nxt = scroll_wrap;
            scroll_red_nxt = scroll_wrap;
            col_ptr_nxt    = scroll_wrap;
          end else begin
            tally_nxt   = tally_inc;
            col_ptr_nxt = scroll_red_r;
          end
        end
      end
    end
    if ((st_r == M_MOD_S) && mod_done) begin
      scroll_red_nxt = mod_rem;
    end
    if ((st_r == M_MOD_C) && mod_done) begin
      col_ptr_nxt = mod_rem;
    end
  end

  // Maintenance sequencer: clearing pass, then reduce scroll and column
  // pointer modulo the frame width; redone after every frame width write.
  always_comb begin
    st_nxt       = st_r;
    mod_start    = 1'b0;
    mod_dividend = {1'b0, scroll_raw_r};
    case (st_r)
      M_CLEAR: begin
        if (&clr_cnt_r) begin
          st_nxt    = M_MOD_S;
          mod_start = 1'b1;
        end
      end
      M_MOD_S: begin
        if (fw_wr) begin
          mod_start = 1'b1;
        end else if (mod_done) begin
          st_nxt       = M_MOD_C;
          mod_start    = 1'b1;
          mod_dividend = {1'b0, scroll_raw_r} + {1'b0, col_idx_r};
        end
      end
      M_MOD_C: begin
        if (fw_wr) begin
          st_nxt    = M_MOD_S;
          mod_start = 1'b1;
        end else if (mod_done) begin
          st_nxt = M_RUN;
        end
      end
      M_RUN: begin
        if (fw_wr) begin
          st_nxt    = M_MOD_S;
          mod_start = 1'b1;
        end
      end
      default: begin
        st_nxt = M_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= M_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == M_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r    <= '0;
      col_idx_r    <= '0;
      scroll_raw_r <= '0;
      scroll_red_r <= '0;
      col_ptr_r    <= '0;
      tally_r      <= '0;
    end else begin
      cur_row_r    <= cur_row_nxt;
      col_idx_r    <= col_idx_nxt;
      scroll_raw_r <= scroll_raw_nxt;
      scroll_red_r <= scroll_red_nxt;
      col_ptr_r    <= col_ptr_nxt;
      tally_r      <= tally_nxt;
    end
  end

  // Frame store port: one address, write or registered read.
  always_comb begin
    if (st_r == M_CLEAR) begin
      mem_addr  = clr_cnt_r;
      mem_we    = 1'b1;
      mem_wdata = '0;
    end else begin
      mem_addr  = q_data.is_tick ? {row_rd, col_ptr_r} : q_data.addr;
      mem_we    = q_pop && q_data.wr_en;
      mem_wdata = q_data.color;
    end
  end
  assign mem_re = q_pop && q_data.is_tick;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= mem[mem_addr];
    end
  end

  // Result pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (q_pop) begin
        p1_v_r <= 1'b1;
      end else if (p1_adv) begin
        p1_v_r <= 1'b0;
      end
      if (p1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p1_tick_r   <= q_data.is_tick;
      p1_status_r <= q_data.oor;
      p1_row_r    <= cur_row_r;
      p1_latch_r  <= q_data.is_tick && is_latch;
      p1_done_r   <= q_data.is_tick && is_done;
    end
    if (p1_adv) begin
      out_status_r <= p1_status_r;
      out_row_r    <= p1_row_r;
      out_red_r    <= p1_tick_r ? !rd_r[0] : 1'b1;
      out_green_r  <= p1_tick_r ? !rd_r[1] : 1'b1;
      out_latch_r  <= p1_latch_r;
      out_done_r   <= p1_done_r;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.row_address = out_row_r;
  assign out_ch.red_low     = out_red_r;
  assign out_ch.green_low   = out_green_r;
  assign out_ch.latch       = out_latch_r;
  assign out_ch.frame_done  = out_done_r;

`ifndef SYNTHESIS
  a_ptr_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == M_RUN) && !fw_wr) |->
      (({1'b0, col_ptr_r} < cfg.fw_eff) && ({1'b0, scroll_red_r} < cfg.fw_eff)))
    else $error("column pointer or scroll not reduced while running");

  a_done_has_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_v_r && p1_done_r) |-> (p1_latch_r && p1_tick_r))
    else $error("frame end without latch on a tick");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == M_CLEAR) |-> (!p1_v_r && !out_v_r && !q_pop))
    else $error("item in flight during clearing pass");
`endif

endmodule
`default_nettype wire

### tb/sv/tb_led_matrix_scan_scroll_core.sv
`timescale 1ns / 100ps

// Checks the LED matrix scan and scroll core against a cycle-free predictor of
// the panel state. Pixel writes and column ticks stream in through in_ch and every
// transfer yields exactly one pin snapshot on out_ch. The predictor runs when
// the input transfer happens and queues the snapshot it expects. The monitor
// compares each output transfer with the oldest queued snapshot.
module tb_led_matrix_scan_scroll_core;
  import lmss_pkg::*;

  // One pixel write or one column tick, as offered on in_ch.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t   action;
    logic [7:0] x;
    logic [3:0] y;
    logic [1:0] color;
  } pixel_op_t;

  // Pin levels of one result, in out_ch field order.
  typedef struct packed {
    logic       status;
    logic [3:0] row_address;
    logic       red_low;
    logic       green_low;
    logic       latch;
    logic       frame_done;
  } pin_state_t;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  // The clearing pass after reset keeps in_ch.ready low while it writes all
  // 4096 pixels, so the quiet-cycle limit must sit well above that pass.
  localparam int IDLE_LIMIT     = 20000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int PHASE_ITEMS    = 100;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  lmss_in_if  in_ch ();
  lmss_out_if out_ch ();

  led_matrix_scan_scroll_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the configuration registers, holding the raw written bits.
  // Clamping happens at use; the block clamps when the register is written.
  logic [8:0] vis_reg;
  logic [4:0] rows_reg;
  logic [8:0] fw_reg;
  logic [7:0] div_reg;

  // Shadow of the panel state.
  logic [1:0] pixel_mem [MAX_ROWS][MAX_FRAME_WIDTH];
  logic [3:0] cur_row;
  logic [7:0] col_idx;
  logic [7:0] scroll_pos;
  logic [7:0] frame_tally;

  pixel_op_t  pending_ops[$];
  pin_state_t expected_pins[$];

  int n_issued;
  int n_results;
  int n_errors;
  int quiet_cycles;
  logic squeeze_armed;

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the panel shadow by one item and returns the pins it should show.
  function automatic pin_state_t panel_step(pixel_op_t op);
    pin_state_t pins;
    int fw;
    int rc;
    int vw;
    int dv;
    int row;
    int col;
    logic [1:0] pix;
    logic last_col;
    logic last_row;
    fw = clip(int'(fw_reg), 1, MAX_FRAME_WIDTH);
    rc = clip(int'(rows_reg), 1, MAX_ROWS);
    vw = clip(int'(vis_reg), 1, 256);
    dv = (div_reg == 8'd0) ? 1 : int'(div_reg);
    pins.row_address = cur_row;

    if (op.action == OP_WRITE) begin
      // A write never moves the scan; data pins idle unlit.
      if (int'(op.x) >= fw || int'(op.y) >= rc) begin
        pins.status = ST_RANGE;
      end else begin
        pixel_mem[op.y][op.x] = op.color;
        pins.status = ST_OK;
      end
      pins.red_low    = 1'b1;
      pins.green_low  = 1'b1;
      pins.latch      = 1'b0;
      pins.frame_done = 1'b0;
      return pins;
    end

    // A row or column left beyond a shrunk register acts as the last one.
    row = (int'(cur_row) < rc) ? int'(cur_row) : rc - 1;
    col = (int'(scroll_pos) + int'(col_idx)) % fw;
    pix = pixel_mem[row][col];
    last_col = int'(col_idx) >= vw - 1;
    last_row = last_col && int'(cur_row) >= rc - 1;

    pins.status     = ST_OK;
    pins.red_low    = ~pix[0];
    pins.green_low  = ~pix[1];
    pins.latch      = last_col;
    pins.frame_done = last_row;

    if (!last_col) begin
      col_idx = col_idx + 8'd1;
    end else begin
      col_idx = 8'd0;
      if (!last_row) begin
        cur_row = cur_row + 4'd1;
      end else begin
        cur_row = 4'd0;
        frame_tally = frame_tally + 8'd1;
        if (int'(frame_tally) >= dv) begin
          frame_tally = 8'd0;
          scroll_pos = 8'((int'(scroll_pos) + 1) % fw);
        end
      end
    end
    return pins;
  endfunction

  // Idle draw for one item: mostly a random gap, with occasional runs of
  // back-to-back transfers.
  function automatic int pick_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      run_left = $urandom_range(16, 64);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic check_pin(string pin, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", pin, want, got);
      n_errors++;
    end
  endtask

  // Sender. The current item stays on the bus until its transfer; the
  // prediction is made at the transfer edge so the shadow sees items in the
  // order the block takes them.
  pixel_op_t cur_op;
  int tx_wait;
  int tx_run;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_wait = 0;
      tx_run = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_pins.push_back(panel_step(cur_op));
        tx_wait = pick_gap(tx_run);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Offer stands until the block takes it.
      end else if (tx_wait > 0) begin
        tx_wait--;
        in_ch.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        cur_op = pending_ops.pop_front();
        in_ch.action      <= cur_op.action;
        in_ch.pixel_x     <= cur_op.x;
        in_ch.pixel_y     <= cur_op.y;
        in_ch.pixel_color <= cur_op.color;
        in_ch.valid       <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver. After each transfer it draws a wait; once, when armed, it
  // holds ready low for a long stretch so the queue and pipeline fill up
  // and in_ch.ready has to drop.
  pin_state_t want;
  int rx_wait;
  int rx_run;
  int hold_left;
  logic squeeze_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
      rx_run = 0;
      hold_left = 0;
      squeeze_done = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_pins.size() == 0) begin
          $error("result transfer with no expected result pending");
          n_errors++;
        end else begin
          want = expected_pins.pop_front();
          check_pin("status", want.status, out_ch.status);
          check_pin("row_address", want.row_address, out_ch.row_address);
          check_pin("red_low", want.red_low, out_ch.red_low);
          check_pin("green_low", want.green_low, out_ch.green_low);
          check_pin("latch", want.latch, out_ch.latch);
          check_pin("frame_done", want.frame_done, out_ch.frame_done);
        end
        rx_wait = pick_gap(rx_run);
      end
      if (squeeze_armed && !squeeze_done) begin
        hold_left = SQUEEZE_CYCLES;
        squeeze_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // A run of cycles with no transfer on either channel means the block hung.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_op(op_kind_t action, int x, int y, int color);
    pixel_op_t op;
    op.action = action;
    op.x      = 8'(x);
    op.y      = 4'(y);
    op.color  = 2'(color);
    pending_ops.push_back(op);
    n_issued++;
  endtask

  // Random items for the current geometry. Most writes land inside the
  // frame so the scan reads back real content; the rest use the whole field
  // range and exercise the out-of-range path.
  task automatic queue_ops(int count, int tick_pct);
    int fw;
    int rc;
    int x;
    int y;
    fw = clip(int'(fw_reg), 1, MAX_FRAME_WIDTH);
    rc = clip(int'(rows_reg), 1, MAX_ROWS);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        x = $urandom_range(0, fw - 1);
        y = $urandom_range(0, rc - 1);
      end else begin
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 15);
      end
      push_op(($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_WRITE,
              x, y, $urandom_range(0, 3));
    end
  endtask

  // Waits at falling edges so that counters updated at the rising edge are
  // settled when read.
  task automatic drain();
    while (n_results < n_issued) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [8:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_VISIBLE_WIDTH:  vis_reg  = value;
      CFG_ROW_COUNT:      rows_reg = value[4:0];
      CFG_FRAME_WIDTH:    fw_reg   = value;
      CFG_SCROLL_DIVIDER: div_reg  = value[7:0];
      default: ;
    endcase
  endtask

  // Only called with nothing in flight, so the shadow can switch at once.
  task automatic set_geometry(int vw, int rc, int fw, int dv);
    write_reg(CFG_VISIBLE_WIDTH, 9'(vw));
    write_reg(CFG_ROW_COUNT, 9'(rc));
    write_reg(CFG_FRAME_WIDTH, 9'(fw));
    write_reg(CFG_SCROLL_DIVIDER, 9'(dv));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Geometries for the random phases: minimum and zero registers (which
  // clamp to one), maximum and over-range registers, a visible width beyond
  // the frame width so reads wrap, and shrinking steps that leave the scan
  // position past the new last column or row.
  int geo [10][4] = '{
    '{4, 2, 8, 1},
    '{1, 1, 1, 0},
    '{0, 0, 0, 255},
    '{3, 3, 5, 2},
    '{256, 16, 256, 2},
    '{511, 31, 511, 3},
    '{7, 5, 3, 1},
    '{2, 1, 2, 1},
    '{5, 4, 6, 1},
    '{16, 3, 12, 4}
  };

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_VISIBLE_WIDTH;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.action  = OP_WRITE;
    in_ch.pixel_x = '0;
    in_ch.pixel_y = '0;
    in_ch.pixel_color = '0;
    out_ch.ready  = 1'b0;
    squeeze_armed = 1'b0;
    n_issued      = 0;
    n_results     = 0;
    n_errors      = 0;

    // Shadow of the reset state: dark frame, scan at the origin.
    for (int r = 0; r < MAX_ROWS; r++) begin
      for (int c = 0; c < MAX_FRAME_WIDTH; c++) pixel_mem[r][c] = 2'd0;
    end
    cur_row     = '0;
    col_idx     = '0;
    scroll_pos  = '0;
    frame_tally = '0;
    vis_reg     = 9'd64;
    rows_reg    = 5'd8;
    fw_reg      = 9'd64;
    div_reg     = 8'd5;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset geometry: writes at the corners of the frame, each colour, just
    // past the last column and row and at the field maxima, then a few ticks
    // that read the first columns of row zero back.
    push_op(OP_WRITE, 0, 0, 3);
    push_op(OP_WRITE, 63, 7, 1);
    push_op(OP_WRITE, 1, 0, 2);
    push_op(OP_WRITE, 64, 0, 3);
    push_op(OP_WRITE, 0, 8, 3);
    push_op(OP_WRITE, 255, 15, 3);
    push_op(OP_WRITE, 255, 0, 0);
    push_op(OP_TICK, 0, 0, 0);
    push_op(OP_TICK, 255, 15, 3);
    push_op(OP_TICK, 0, 0, 0);
    drain();

    // Tiny panel: the column index is already past the new last column, so
    // the first tick latches at once. Ten ticks run through several frames
    // with a scroll step at every frame end.
    set_geometry(2, 2, 4, 1);
    push_op(OP_WRITE, 3, 1, 1);
    push_op(OP_WRITE, 0, 1, 2);
    push_op(OP_WRITE, 4, 1, 3);
    push_op(OP_WRITE, 3, 2, 3);
    repeat (10) push_op(OP_TICK, 0, 0, 0);
    drain();

    for (int p = 0; p < 12; p++) begin
      if (p < 10) begin
        set_geometry(geo[p][0], geo[p][1], geo[p][2], geo[p][3]);
      end else begin
        set_geometry($urandom_range(1, 12), $urandom_range(1, 6),
                     $urandom_range(1, 16), $urandom_range(0, 4));
      end
      queue_ops(PHASE_ITEMS, 75);
      if (p == 4) begin
        // Long receiver stall while the sender keeps offering items.
        @(posedge clk);
        squeeze_armed <= 1'b1;
      end
      drain();
    end

    // Back to a full-width single row: columns hidden while the frame was
    // narrow become visible again.
    set_geometry(64, 1, 64, 255);
    queue_ops(64, 100);
    drain();

    // Results trail their transfer through the queue and the result pipeline; give
    // stray ones time to show up before the verdict.
    repeat (8) @(posedge clk);
    if (expected_pins.size() != 0) begin
      $error("%0d expected results never arrived", expected_pins.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
